>>> design/area_ordered_box_nms_assert.svh
// assertion macros for the box suppression block
// used by the top level; no other dependencies
`ifndef AREA_ORDERED_BOX_NMS_ASSERT_SVH
`define AREA_ORDERED_BOX_NMS_ASSERT_SVH
`ifndef SYNTH
`define AOB_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define AOB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define AOB_ASSERT_IMPL(lbl, ante, cons, msg)
`define AOB_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> design/aob_pkg.sv
// shared types for the area ordered box suppression block
// no dependencies
package aob_pkg;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [14:0]        w;
    logic [14:0]        h;
  } box_t;

  typedef struct packed {
    logic signed [15:0] box_x;
    logic signed [15:0] box_y;
    logic [14:0]        box_width;
    logic [14:0]        box_height;
    logic               last_box;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] kept_x;
    logic signed [15:0] kept_y;
    logic [14:0]        kept_width;
    logic [14:0]        kept_height;
    logic [5:0]         source_index;
    logic               last_kept;
  } out_item_t;

  typedef struct packed {
    box_t       box;
    logic [5:0] idx;
  } kept_entry_t;

  // overlap unit status
  typedef struct packed {
    logic done;
    logic ok;
  } iou_res_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SCAN,
    ST_SCAN_END,
    ST_PICK,
    ST_CMP_RD,
    ST_CMP_WAIT,
    ST_CMP_RUN,
    ST_EMIT_RD,
    ST_EMIT_WAIT,
    ST_EMIT_HOLD
  } state_t;

  localparam logic [2:0] ADDR_THRESHOLD = 3'd0;
  localparam logic [16:0] THR_RESET = 17'd19661;

endpackage

>>> design/aob_iou_unit.sv
// pipelined overlap test of two boxes: inter*65536 <= thr*union
// depends on aob_pkg
module aob_iou_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  aob_pkg::box_t     box_a,
  input  aob_pkg::box_t     box_b,
  input  logic [16:0]       thr,
  output aob_pkg::iou_res_t res
);

  logic [3:0]  vld_r;
  logic [14:0] ex_r, ey_r;
  logic [29:0] aa_r, ab_r, aa2_r, ab2_r, inter_r, inter2_r, inter3_r;
  logic [30:0] uni_r, uni2_r;
  logic [47:0] prod_r;

  logic signed [17:0] ax0, ax1, bx0, bx1, ay0, ay1, by0, by1;
  logic signed [17:0] xlo, xhi, ylo, yhi, dx, dy;

  // edges and clamped extents
  always_comb begin
    ax0 = 18'(box_a.x);
    ax1 = 18'(box_a.x) + 18'($signed({1'b0, box_a.w}));
    bx0 = 18'(box_b.x);
    bx1 = 18'(box_b.x) + 18'($signed({1'b0, box_b.w}));
    ay0 = 18'(box_a.y);
    ay1 = 18'(box_a.y) + 18'($signed({1'b0, box_a.h}));
    by0 = 18'(box_b.y);
    by1 = 18'(box_b.y) + 18'($signed({1'b0, box_b.h}));
    xlo = (ax0 > bx0) ? ax0 : bx0;
    xhi = (ax1 < bx1) ? ax1 : bx1;
    ylo = (ay0 > by0) ? ay0 : by0;
    yhi = (ay1 < by1) ? ay1 : by1;
    dx  = xhi - xlo;
    dy  = yhi - ylo;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], start};
    end
  end

  // stage 1 extents and areas, 2 intersection, 3 union, 4 product
  always_ff @(posedge clk) begin
    ex_r     <= (dx > 18'sd0) ? dx[14:0] : 15'd0;
    ey_r     <= (dy > 18'sd0) ? dy[14:0] : 15'd0;
    aa_r     <= box_a.w * box_a.h;
    ab_r     <= box_b.w * box_b.h;
    inter_r  <= ex_r * ey_r;
    aa2_r    <= aa_r;
    ab2_r    <= ab_r;
    uni_r    <= {1'b0, aa2_r} + {1'b0, ab2_r} - {1'b0, inter_r};
    inter2_r <= inter_r;
    prod_r   <= thr * uni_r;
    uni2_r   <= uni_r;
    inter3_r <= inter2_r;
  end

  assign res.done = vld_r[3];
  assign res.ok   = (uni2_r != 31'd0) && ({2'b00, inter3_r, 16'd0} <= prod_r);

endmodule

>>> design/area_ordered_box_nms.sv
// Greedy area-ordered box suppression. Boxes load one per transfer into an
// on-chip box memory until the one flagged last_box; loads past capacity
// (min(MAX_BOXES,64)) are dropped. Processing then takes, for each of the N
// loaded boxes, one scan of the box memory (one read per cycle) to pick the
// largest unused box, plus a pipelined overlap test against each already
// kept box, plus a memory read and a held output per emitted result. The
// input is stalled from the last box until the final result transfers.
// depends on aob_pkg, aob_iou_unit and area_ordered_box_nms_assert.svh
`include "area_ordered_box_nms_assert.svh"
module area_ordered_box_nms #(
  parameter int MAX_BOXES = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  aob_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output aob_pkg::out_item_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int CAP = (MAX_BOXES < 64) ? MAX_BOXES : 64;
  localparam int IW  = (CAP > 1) ? $clog2(CAP) : 1;
  localparam int CW  = $clog2(CAP + 1);

  aob_pkg::state_t state_r, state_nxt;

  logic [16:0]   thr_r;
  logic [CW-1:0] load_cnt_r, kept_cnt_r;
  logic [IW-1:0] scan_addr_r, scan_q_r, k_r, emit_r;
  logic          scan_vld_r, found_r;
  logic [CAP-1:0] used_r;
  aob_pkg::box_t best_box_r;
  logic [IW-1:0] best_idx_r;
  logic [29:0]   best_area_r, rd_area;

  aob_pkg::box_t       box_mem [CAP];
  aob_pkg::box_t       box_rd_r;
  aob_pkg::kept_entry_t kept_mem [CAP];
  aob_pkg::kept_entry_t kept_rd_r;
  logic [IW-1:0]       kept_raddr;

  aob_pkg::out_item_t out_r;
  logic               out_valid_r;
  aob_pkg::iou_res_t  iou_res;

  logic in_xfer, out_xfer, box_we, keep_now, drop_now, scan_last, k_last, emit_last;

  assign in_stall  = (state_r != aob_pkg::ST_LOAD);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_xfer  = out_valid_r && !out_stall;
  assign box_we    = in_xfer && (load_cnt_r < CW'(CAP));
  assign scan_last = (CW'(scan_addr_r) + CW'(1)) == load_cnt_r;
  assign k_last    = (CW'(k_r) + CW'(1)) == kept_cnt_r;
  assign emit_last = (CW'(emit_r) + CW'(1)) == kept_cnt_r;
  assign rd_area   = box_rd_r.w * box_rd_r.h;
  assign kept_raddr = (state_r == aob_pkg::ST_EMIT_RD) ? emit_r : k_r;

  // configuration port
  assign pready = 1'b1;
  assign prdata = {15'd0, thr_r};
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= aob_pkg::THR_RESET;
    end else if (psel && penable && pwrite && paddr == aob_pkg::ADDR_THRESHOLD) begin
      thr_r <= pwdata[16:0];
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (box_we) begin
      box_mem[load_cnt_r[IW-1:0]] <= '{x: in_data.box_x, y: in_data.box_y,
                                       w: in_data.box_width, h: in_data.box_height};
    end
    box_rd_r <= box_mem[scan_addr_r];
    if (keep_now) begin
      kept_mem[kept_cnt_r[IW-1:0]] <= '{box: best_box_r, idx: 6'(best_idx_r)};
    end
    kept_rd_r <= kept_mem[kept_raddr];
  end

  aob_iou_unit u_iou (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == aob_pkg::ST_CMP_WAIT),
    .box_a (best_box_r),
    .box_b (kept_rd_r.box),
    .thr   (thr_r),
    .res   (iou_res)
  );

  // next state and decisions
  always_comb begin
    state_nxt = state_r;
    keep_now  = 1'b0;
    drop_now  = 1'b0;
    unique case (state_r)
      aob_pkg::ST_LOAD: begin
        if (in_xfer && in_data.last_box && (box_we || load_cnt_r != '0)) begin
          state_nxt = aob_pkg::ST_SCAN;
        end
      end
      aob_pkg::ST_SCAN: begin
        if (scan_last) state_nxt = aob_pkg::ST_SCAN_END;
      end
      aob_pkg::ST_SCAN_END: state_nxt = aob_pkg::ST_PICK;
      aob_pkg::ST_PICK: begin
        if (!found_r) begin
          state_nxt = aob_pkg::ST_EMIT_RD;
        end else if (kept_cnt_r == '0) begin
          keep_now  = 1'b1;
          state_nxt = aob_pkg::ST_SCAN;
        end else begin
          state_nxt = aob_pkg::ST_CMP_RD;
        end
      end
      aob_pkg::ST_CMP_RD:   state_nxt = aob_pkg::ST_CMP_WAIT;
      aob_pkg::ST_CMP_WAIT: state_nxt = aob_pkg::ST_CMP_RUN;
      aob_pkg::ST_CMP_RUN: begin
        if (iou_res.done) begin
          if (!iou_res.ok) begin
            drop_now  = 1'b1;
            state_nxt = aob_pkg::ST_SCAN;
          end else if (k_last) begin
            keep_now  = 1'b1;
            state_nxt = aob_pkg::ST_SCAN;
          end else begin
            state_nxt = aob_pkg::ST_CMP_RD;
          end
        end
      end
      aob_pkg::ST_EMIT_RD:   state_nxt = aob_pkg::ST_EMIT_WAIT;
      aob_pkg::ST_EMIT_WAIT: state_nxt = aob_pkg::ST_EMIT_HOLD;
      aob_pkg::ST_EMIT_HOLD: begin
        if (out_xfer) state_nxt = emit_last ? aob_pkg::ST_LOAD : aob_pkg::ST_EMIT_RD;
      end
      default: state_nxt = aob_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= aob_pkg::ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // counters, scan and candidate tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_cnt_r  <= '0;
      kept_cnt_r  <= '0;
      scan_addr_r <= '0;
      scan_vld_r  <= 1'b0;
      found_r     <= 1'b0;
      used_r      <= '0;
      k_r         <= '0;
      emit_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      scan_vld_r <= (state_r == aob_pkg::ST_SCAN);
      scan_q_r   <= scan_addr_r;
      if (box_we) load_cnt_r <= load_cnt_r + CW'(1);
      if (state_r == aob_pkg::ST_LOAD && state_nxt == aob_pkg::ST_SCAN) begin
        used_r     <= '0;
        kept_cnt_r <= '0;
      end
      // start a fresh scan
      if (state_nxt == aob_pkg::ST_SCAN && state_r != aob_pkg::ST_SCAN) begin
        scan_addr_r <= '0;
        found_r     <= 1'b0;
      end else if (state_r == aob_pkg::ST_SCAN && !scan_last) begin
        scan_addr_r <= scan_addr_r + IW'(1);
      end
      // largest unused area, earliest load wins ties
      if (scan_vld_r && !used_r[scan_q_r] && (!found_r || rd_area > best_area_r)) begin
        found_r     <= 1'b1;
        best_box_r  <= box_rd_r;
        best_idx_r  <= scan_q_r;
        best_area_r <= rd_area;
      end
      if (keep_now || drop_now) used_r[best_idx_r] <= 1'b1;
      if (keep_now) kept_cnt_r <= kept_cnt_r + CW'(1);
      if (state_r == aob_pkg::ST_PICK) k_r <= '0;
      else if (state_r == aob_pkg::ST_CMP_RUN && iou_res.done) k_r <= k_r + IW'(1);
      // result output
      if (state_r == aob_pkg::ST_PICK && !found_r) emit_r <= '0;
      if (state_r == aob_pkg::ST_EMIT_WAIT) begin
        out_valid_r <= 1'b1;
        out_r <= '{kept_x: kept_rd_r.box.x, kept_y: kept_rd_r.box.y,
                   kept_width: kept_rd_r.box.w, kept_height: kept_rd_r.box.h,
                   source_index: kept_rd_r.idx, last_kept: emit_last};
      end else if (out_xfer) begin
        out_valid_r <= 1'b0;
        emit_r      <= emit_r + IW'(1);
      end
      // set done, clear for the next load
      if (state_r != aob_pkg::ST_LOAD && state_nxt == aob_pkg::ST_LOAD) begin
        load_cnt_r <= '0;
        kept_cnt_r <= '0;
      end
      if (state_r == aob_pkg::ST_PICK && !found_r && kept_cnt_r == '0) load_cnt_r <= '0;
    end
  end

  // an empty kept list at the pick decision clears the load count
  // (the pick decision only clears load_cnt_r; it still enters the emit phase)

  `AOB_ASSERT_IMPL(a_no_load_while_out, out_valid_r, in_stall, "load during result output")
  `AOB_ASSERT_IMPL(a_kept_le_loaded, 1'b1, kept_cnt_r <= load_cnt_r, "kept exceeds loaded")
  `AOB_ASSERT_NEXT(a_last_ends_set, out_xfer && out_r.last_kept,
                   state_r == aob_pkg::ST_LOAD && load_cnt_r == '0, "set not closed")

endmodule
